[rtl/qsmm_pkg.sv]
// shared types and constants for the quadratic sequence merge
`timescale 1ns / 1ps
package qsmm_pkg;
   localparam int NUM_ENTRIES = 64;
   localparam int IDX_W = 6;
   localparam int VAL_W = 50;
   localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [5:0]  entry_index;
      logic [15:0] coef_square;
      logic [15:0] coef_linear;
      logic [15:0] coef_const;
   } req_type;

   typedef struct packed {
      logic [49:0] min_value;
      logic [5:0]  source_entry;
      logic        empty_res;
   } rsp_type;

   // one word handed from cell to cell along the chain
   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] index;
   } best_type;

   // controls broadcast to every cell
   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] load_index;
      logic [15:0]      coef_square;
      logic [15:0]      coef_linear;
      logic [15:0]      coef_const;
      logic             advance;
      logic [IDX_W-1:0] advance_index;
   } cell_ctl_type;
endpackage

[rtl/qsmm_cell.sv]
// one table entry: coefficients, argument, valid mark and a compare stage
`timescale 1ns / 1ps
module qsmm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [qsmm_pkg::IDX_W-1:0] my_index,
   input  qsmm_pkg::cell_ctl_type ctl,
   input  qsmm_pkg::best_type    best_prev,
   output qsmm_pkg::best_type    best_next
);
   logic [15:0] a_ff, b_ff, c_ff, x_ff;
   logic        valid_ff;
   logic [31:0] ax_ff, ax_in;
   logic [49:0] val_ff;
   logic [49:0] val_in;
   qsmm_pkg::best_type best_ff, best_in;

   // value pipeline: a*x, then (a*x+b)*x+c (horner, two registered products)
   assign ax_in = 32'(a_ff) * 32'(x_ff);
   assign val_in = 50'(({18'd0, ax_ff} + {34'd0, b_ff}) * {34'd0, x_ff}) + 50'(c_ff);

   // compare against the running best handed in from the neighbor
   always_comb begin
      best_in = best_prev;
      if (valid_ff && (!best_prev.found || val_ff < best_prev.value)) begin
         best_in.found = 1'b1;
         best_in.value = val_ff;
         best_in.index = my_index;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      val_ff  <= val_in;
      best_ff <= best_in;
      if (ctl.load && ctl.load_index == my_index) begin
         a_ff <= ctl.coef_square;
         b_ff <= ctl.coef_linear;
         c_ff <= ctl.coef_const;
         x_ff <= 16'd1;
      end else if (ctl.advance && ctl.advance_index == my_index) begin
         x_ff <= x_ff + 16'd1;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load && ctl.load_index == my_index) begin
         valid_ff <= 1'b1;
      end else if (ctl.advance && ctl.advance_index == my_index && x_ff == 16'hFFFF) begin
         valid_ff <= 1'b0;
      end
   end

   assign best_next = best_ff;
endmodule

[rtl/quadratic_sequence_min_merge.sv]
// top level: chain of entry cells and the item sequencer
`timescale 1ns / 1ps
// load: no result. pop: a scan from accept to result; the running minimum
// ripples one cell per cycle down the chain of entry cells, after the
// values have settled in the cells' value pipelines.
// one pop at a time, and no new item goes in until it ends; a finished result
// waits in the output register while new items go in, and a pop that ends
// while that register is still full holds the input off until it drains.
// synchronous reset clears all valid marks and the sequencer at once.
module quadratic_sequence_min_merge (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  qsmm_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output qsmm_pkg::rsp_type  rsp_data
);
   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   localparam int N = qsmm_pkg::NUM_ENTRIES;
   localparam int WAIT = N + 3;

   state_type state_ff;
   logic [qsmm_pkg::CNT_W+1:0] count_ff;
   qsmm_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic rsp_fire;
   logic adv_ff;
   logic [qsmm_pkg::IDX_W-1:0] adv_idx_ff;
   qsmm_pkg::cell_ctl_type ctl;
   qsmm_pkg::best_type chain [N+1];

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // scan result moves to the output register once it has room
   assign rsp_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      ctl               = '0;
      ctl.load          = req_valid && req_ready && req_data.kind == qsmm_pkg::KIND_LOAD
                          && 32'(req_data.entry_index) < N;
      ctl.load_index    = req_data.entry_index;
      ctl.coef_square   = req_data.coef_square;
      ctl.coef_linear   = req_data.coef_linear;
      ctl.coef_const    = req_data.coef_const;
      ctl.advance       = adv_ff;
      ctl.advance_index = adv_idx_ff;
   end

   // head of the chain: nothing found yet
   assign chain[0] = '0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      qsmm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .my_index  (qsmm_pkg::IDX_W'(i)),
         .ctl       (ctl),
         .best_prev (chain[i]),
         .best_next (chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         adv_ff       <= 1'b0;
         count_ff     <= '0;
      end else begin
         // winner advances its argument in the cycle after the result is taken in
         adv_ff       <= rsp_fire && chain[N].found;
         rsp_valid_ff <= rsp_fire || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            ST_IDLE: begin
               // pop: wait for values to settle and the minimum to ripple out
               if (req_valid && req_ready && req_data.kind == qsmm_pkg::KIND_POP) begin
                  state_ff <= ST_SCAN;
                  count_ff <= '0;
               end
            end
            ST_SCAN: begin
               count_ff <= count_ff + {{(qsmm_pkg::CNT_W+1){1'b0}}, 1'b1};
               if (32'(count_ff) == WAIT - 1) state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_fire) begin
                  rsp_ff.empty_res    <= !chain[N].found;
                  rsp_ff.min_value    <= chain[N].found ? chain[N].value : '0;
                  rsp_ff.source_entry <= chain[N].found ? chain[N].index : '0;
                  adv_idx_ff <= chain[N].index;
                  state_ff   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
